[rtl/bpsc_pkg.sv]
// ----------------------------------------------------------------------------
// bpsc_pkg: shared types and constants
// Word formats, configuration layout and event codes for the button press
// and sleep controller.
// ----------------------------------------------------------------------------
package bpsc_pkg;

   localparam int MAX_TABS = 8;

   localparam logic [9:0]  HOLD_MAX = 10'h3FF;
   localparam logic [15:0] IDLE_MAX = 16'hFFFF;

   // Configuration register indexes
   localparam logic [2:0] REG_MIN_PRESS   = 3'd0;
   localparam logic [2:0] REG_LONG_PRESS  = 3'd1;
   localparam logic [2:0] REG_SLEEP_TICKS = 3'd2;
   localparam logic [2:0] REG_TAB_COUNT   = 3'd3;
   localparam logic [2:0] REG_BUTTON_EXT  = 3'd4;

   // Reset values of the configuration registers
   localparam logic [9:0]  MIN_PRESS_RESET   = 10'd30;
   localparam logic [9:0]  LONG_PRESS_RESET  = 10'd500;
   localparam logic [15:0] SLEEP_TICKS_RESET = 16'd30000;
   localparam logic [3:0]  TAB_COUNT_RESET   = 4'd6;

   // Press event codes
   localparam logic [1:0] EV_NONE  = 2'd0;
   localparam logic [1:0] EV_SHORT = 2'd1;
   localparam logic [1:0] EV_LONG  = 2'd2;
   localparam logic [1:0] EV_SLEEP = 2'd3;

   typedef struct packed {
      logic       button_pressed;
      logic       wake_request;
      logic       activity;
      logic       set_tab_valid;
      logic [2:0] set_tab_value;
   } req_type;

   typedef struct packed {
      logic [1:0] press_event;
      logic       woke;
      logic       sleeping;
      logic [2:0] current_tab;
      logic       redraw;
   } rsp_type;

   typedef struct packed {
      logic [9:0]  min_press_ticks;
      logic [9:0]  long_press_ticks;
      logic [15:0] sleep_ticks;
      logic [3:0]  tab_count;
      logic        button_external;
   } cfg_type;

endpackage

[rtl/bpsc_csr.sv]
// ----------------------------------------------------------------------------
// bpsc_csr: configuration registers
// Write-only register file; decodes the index and holds the five settings.
// ----------------------------------------------------------------------------
module bpsc_csr (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_we,
   input  logic [2:0]         csr_index,
   input  logic [15:0]        csr_wdata,
   output bpsc_pkg::cfg_type  cfg
);

   bpsc_pkg::cfg_type cfg_ff;
   bpsc_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            bpsc_pkg::REG_MIN_PRESS:   cfg_in.min_press_ticks  = csr_wdata[9:0];
            bpsc_pkg::REG_LONG_PRESS:  cfg_in.long_press_ticks = csr_wdata[9:0];
            bpsc_pkg::REG_SLEEP_TICKS: cfg_in.sleep_ticks      = csr_wdata;
            bpsc_pkg::REG_TAB_COUNT:   cfg_in.tab_count        = csr_wdata[3:0];
            bpsc_pkg::REG_BUTTON_EXT:  cfg_in.button_external  = csr_wdata[0];
            default:                   cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_press_ticks  <= bpsc_pkg::MIN_PRESS_RESET;
         cfg_ff.long_press_ticks <= bpsc_pkg::LONG_PRESS_RESET;
         cfg_ff.sleep_ticks      <= bpsc_pkg::SLEEP_TICKS_RESET;
         cfg_ff.tab_count        <= bpsc_pkg::TAB_COUNT_RESET;
         cfg_ff.button_external  <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

[rtl/bpsc_core.sv]
// ----------------------------------------------------------------------------
// bpsc_core: tick state and update logic
// Holds sleep, wake latch, hold and idle counters and the tab; computes the
// next state and the result word of one tick.
// ----------------------------------------------------------------------------
module bpsc_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               step,
   input  bpsc_pkg::cfg_type  cfg,
   input  bpsc_pkg::req_type  item,
   output bpsc_pkg::rsp_type  result
);

   logic        asleep_ff, asleep_in;
   logic        wake_latched_ff, wake_latched_in;
   logic        button_held_ff, button_held_in;
   logic [9:0]  hold_count_ff, hold_count_in;
   logic [15:0] idle_count_ff, idle_count_in;
   logic [2:0]  tab_index_ff, tab_index_in;

   always_comb begin
      logic [3:0] tabs;
      logic [9:0] hold_next;
      logic [3:0] wrap;
      logic       done;
      logic       is_long;
      logic       is_short;

      asleep_in       = asleep_ff;
      wake_latched_in = wake_latched_ff;
      button_held_in  = button_held_ff;
      hold_count_in   = hold_count_ff;
      tab_index_in    = tab_index_ff;
      result          = '0;
      done            = 1'b0;
      wrap            = '0;

      // clamp tab count into 1..MAX_TABS
      if (cfg.tab_count == 4'd0) begin
         tabs = 4'd1;
      end else if (cfg.tab_count > 4'(bpsc_pkg::MAX_TABS)) begin
         tabs = 4'(bpsc_pkg::MAX_TABS);
      end else begin
         tabs = cfg.tab_count;
      end

      hold_next = (hold_count_ff != bpsc_pkg::HOLD_MAX) ? hold_count_ff + 10'd1
                                                        : hold_count_ff;
      is_long   = hold_next >= cfg.long_press_ticks;
      is_short  = (hold_next >= cfg.min_press_ticks) && !is_long;

      idle_count_in = (idle_count_ff != bpsc_pkg::IDLE_MAX) ? idle_count_ff + 16'd1
                                                            : idle_count_ff;

      if (item.set_tab_valid) begin
         tab_index_in  = ({1'b0, item.set_tab_value} < tabs) ? item.set_tab_value
                                                              : 3'(tabs - 4'd1);
         idle_count_in = '0;
         result.redraw = 1'b1;
      end
      if (item.activity) begin
         wake_latched_in = 1'b1;
         idle_count_in   = '0;
      end
      if (item.wake_request) begin
         wake_latched_in = 1'b1;
      end

      // latched wake consumed at the start of the update, only while asleep
      if (wake_latched_in && asleep_ff) begin
         wake_latched_in = 1'b0;
         asleep_in       = 1'b0;
         idle_count_in   = '0;
         result.woke     = 1'b1;
         result.redraw   = 1'b1;
      end

      // advance tab modulo the count; tab may sit beyond a shrunk count
      wrap = {1'b0, tab_index_in} + 4'd1;
      for (int i = 0; i < bpsc_pkg::MAX_TABS; i++) begin
         if (wrap >= tabs) begin
            wrap = wrap - tabs;
         end
      end

      if (asleep_in) begin
         if (!cfg.button_external) begin
            if (item.button_pressed) begin
               button_held_in = 1'b1;
               hold_count_in  = button_held_ff ? hold_next : '0;
            end else if (button_held_ff) begin
               button_held_in = 1'b0;
               if (hold_next >= cfg.min_press_ticks) begin
                  asleep_in     = 1'b0;
                  idle_count_in = '0;
                  result.woke   = 1'b1;
                  result.redraw = 1'b1;
               end
            end
         end
         done = 1'b1;
      end else begin
         if (item.activity) begin
            result.redraw = 1'b1;
         end
         if (!cfg.button_external) begin
            if (item.button_pressed) begin
               button_held_in = 1'b1;
               hold_count_in  = button_held_ff ? hold_next : '0;
            end else if (button_held_ff) begin
               idle_count_in  = '0;
               button_held_in = 1'b0;
               done           = 1'b1;
               if (is_short) begin
                  tab_index_in       = wrap[2:0];
                  result.press_event = bpsc_pkg::EV_SHORT;
                  result.redraw      = 1'b1;
               end else if (is_long) begin
                  result.press_event = bpsc_pkg::EV_LONG;
                  result.redraw      = 1'b1;
               end
            end
         end
      end

      if (!done && (idle_count_in > cfg.sleep_ticks)) begin
         asleep_in          = 1'b1;
         result.press_event = bpsc_pkg::EV_SLEEP;
      end

      result.sleeping    = asleep_in;
      result.current_tab = tab_index_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         asleep_ff       <= 1'b0;
         wake_latched_ff <= 1'b0;
         button_held_ff  <= 1'b0;
         hold_count_ff   <= '0;
         idle_count_ff   <= '0;
         tab_index_ff    <= '0;
      end else if (step) begin
         asleep_ff       <= asleep_in;
         wake_latched_ff <= wake_latched_in;
         button_held_ff  <= button_held_in;
         hold_count_ff   <= hold_count_in;
         idle_count_ff   <= idle_count_in;
         tab_index_ff    <= tab_index_in;
      end
   end

endmodule

[rtl/button_press_sleep_controller.sv]
// ----------------------------------------------------------------------------
// button_press_sleep_controller: button classifier with inactivity sleep
// One tick word in, one status word out; short/long press classing, tab
// cycling, wake latching and idle sleep.
// ----------------------------------------------------------------------------
//
//   channel | direction | handshake          | word
//   --------+-----------+--------------------+---------------------------
//   req     | in        | req_valid/req_ready| req_data (one tick)
//   rsp     | out       | rsp_valid/rsp_ready| rsp_data (tick status)
//   csr     | in        | csr_we, no wait    | csr_index, csr_wdata
//
// Each tick word is latched into an input register, evaluated against the
// state registers, and written to the output register; one word per cycle
// is sustained while the output is not stalled.
// The state update happens when the word moves from input to output
// register; a stalled output with full input holds both and drops req_ready.
// Synchronous reset clears state, valid flags and configuration defaults.
//
module button_press_sleep_controller (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  bpsc_pkg::req_type  req_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output bpsc_pkg::rsp_type  rsp_data,
   input  logic               csr_we,
   input  logic [2:0]         csr_index,
   input  logic [15:0]        csr_wdata
);

   bpsc_pkg::cfg_type cfg;

   logic              in_valid_ff, in_valid_in;
   bpsc_pkg::req_type in_data_ff;
   logic              out_valid_ff, out_valid_in;
   bpsc_pkg::rsp_type out_data_ff;
   bpsc_pkg::rsp_type tick_result;
   logic              advance;

   bpsc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   bpsc_core u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .cfg    (cfg),
      .item   (in_data_ff),
      .result (tick_result)
   );

   // Advance the held word when the output register is free or drains now
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in  = in_valid_ff;
      out_valid_in = out_valid_ff;
      if (req_ready) begin
         in_valid_in = req_valid;
      end
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers: load on handshake, hold otherwise
   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         in_data_ff <= req_data;
      end
      if (advance) begin
         out_data_ff <= tick_result;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule

[bench/tb_button_press_sleep_controller.sv]
// ----------------------------------------------------------------------------
// tb_button_press_sleep_controller: self-checking bench for the press classifier
// Drives one tick word per handshake, predicts every status word with an
// in-bench model of the press, wake and sleep rules, and compares each result
// field by field. Directed cases first, then randomized press sequences over
// several register settings, with random idling on both channels.
// ----------------------------------------------------------------------------
module tb_button_press_sleep_controller;

   // Generous ceiling on run length, in clock cycles
   localparam int CYCLE_LIMIT = 400000;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   bpsc_pkg::req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   bpsc_pkg::rsp_type rsp_data;
   logic    csr_we;
   logic [2:0]  csr_index;
   logic [15:0] csr_wdata;

   button_press_sleep_controller uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Free-running clock, period 20
   initial clock = 1'b0;
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // ------------------------------------------------------------------------
   // Shadow copy of the registers and state of the controller
   // ------------------------------------------------------------------------
   logic [9:0]  cfg_min;
   logic [9:0]  cfg_long;
   logic [15:0] cfg_sleep;
   logic [3:0]  cfg_tabs;
   logic        cfg_ext;

   logic        st_asleep;
   logic        st_wake;
   logic        st_held;
   logic [9:0]  st_hold;
   logic [15:0] st_idle;
   logic [2:0]  st_tab;

   // Status words predicted and not yet seen on the result channel
   bpsc_pkg::rsp_type status_q[$];

   // Bench controls and bookkeeping
   logic src_gaps_on  = 1'b1;
   logic sink_gaps_on = 1'b1;
   int   hold_off_left = 0;
   int   stall_left    = 0;
   int   words_sent    = 0;
   int   words_checked = 0;
   int   mismatch_count = 0;
   int   cycle_count   = 0;
   int   input_stalls  = 0;
   int   seen_short = 0, seen_long = 0, seen_sleep = 0, seen_woke = 0;

   // Evaluate one tick against the shadow state and return the status word
   function automatic bpsc_pkg::rsp_type next_status(bpsc_pkg::req_type w);
      bpsc_pkg::rsp_type s;
      logic [1:0] press_ev;
      logic       woke;
      logic       redraw;
      logic       done;
      logic       sleeping_now;
      logic       is_long;
      logic       is_short;
      logic [9:0] hold_len;
      int         ntabs;
      press_ev = bpsc_pkg::EV_NONE;
      woke     = 1'b0;
      redraw   = 1'b0;
      done     = 1'b0;
      // Zero tabs acts as one, anything above the maximum as the maximum
      ntabs = (cfg_tabs < 1) ? 1 : ((cfg_tabs > bpsc_pkg::MAX_TABS) ? bpsc_pkg::MAX_TABS
                                                                    : int'(cfg_tabs));

      if (st_idle != bpsc_pkg::IDLE_MAX) st_idle = st_idle + 16'd1;

      if (w.set_tab_valid) begin
         st_tab  = (int'(w.set_tab_value) < ntabs) ? w.set_tab_value : 3'(ntabs - 1);
         st_idle = '0;
         redraw  = 1'b1;
      end
      if (w.activity) begin
         st_wake = 1'b1;
         st_idle = '0;
      end
      if (w.wake_request) st_wake = 1'b1;

      // A latched wake only takes effect on a sleeping display
      if (st_wake && st_asleep) begin
         st_wake   = 1'b0;
         st_asleep = 1'b0;
         st_idle   = '0;
         woke      = 1'b1;
         redraw    = 1'b1;
      end

      sleeping_now = st_asleep;
      if (!sleeping_now && w.activity) redraw = 1'b1;

      // An external button leaves the hold tracking frozen
      if (!cfg_ext) begin
         if (w.button_pressed) begin
            if (!st_held) begin
               st_held = 1'b1;
               st_hold = '0;
            end else if (st_hold != bpsc_pkg::HOLD_MAX) begin
               st_hold = st_hold + 10'd1;
            end
         end else if (st_held) begin
            hold_len = (st_hold != bpsc_pkg::HOLD_MAX) ? st_hold + 10'd1 : bpsc_pkg::HOLD_MAX;
            st_held  = 1'b0;
            if (sleeping_now) begin
               // Asleep: a long enough press only wakes, short ones are dropped
               if (hold_len >= cfg_min) begin
                  st_asleep = 1'b0;
                  st_idle   = '0;
                  woke      = 1'b1;
                  redraw    = 1'b1;
               end
            end else begin
               is_long  = (hold_len >= cfg_long);
               is_short = (hold_len >= cfg_min) && !is_long;
               st_idle  = '0;
               if (is_short) begin
                  st_tab   = 3'((int'(st_tab) + 1) % ntabs);
                  press_ev = bpsc_pkg::EV_SHORT;
                  redraw   = 1'b1;
               end else if (is_long) begin
                  press_ev = bpsc_pkg::EV_LONG;
                  redraw   = 1'b1;
               end
               done = 1'b1;
            end
         end
      end
      if (sleeping_now) done = 1'b1;

      if (!done && st_idle > cfg_sleep) begin
         st_asleep = 1'b1;
         press_ev  = bpsc_pkg::EV_SLEEP;
      end

      s.press_event = press_ev;
      s.woke        = woke;
      s.sleeping    = st_asleep;
      s.current_tab = st_tab;
      s.redraw      = redraw;
      return s;
   endfunction

   // Print one mismatch line and count it
   task automatic flag_mismatch(input string msg);
      mismatch_count++;
      $display("MISMATCH @%0d: %s", cycle_count, msg);
   endtask

   // ------------------------------------------------------------------------
   // Result channel: sink with random stalls and a long hold-off on request
   // ------------------------------------------------------------------------
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_left > 0) begin
            // Hold off long enough for the block to fill up and drop req_ready
            rsp_ready = 1'b0;
            hold_off_left--;
         end else if (stall_left > 0) begin
            rsp_ready = 1'b0;
            stall_left--;
         end else if (sink_gaps_on && $urandom_range(0, 9) == 0) begin
            rsp_ready  = 1'b0;
            stall_left = $urandom_range(0, 18);
         end else begin
            rsp_ready = 1'b1;
         end
      end
   end

   // Compare every accepted status word with the oldest prediction
   always @(posedge clock) begin
      bpsc_pkg::rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (status_q.size() == 0) begin
            flag_mismatch($sformatf("status word %h with nothing expected", rsp_data));
         end else begin
            want = status_q.pop_front();
            words_checked++;
            if (rsp_data.press_event !== want.press_event)
               flag_mismatch($sformatf("word %0d press_event %0d, want %0d", words_checked,
                                       rsp_data.press_event, want.press_event));
            if (rsp_data.woke !== want.woke)
               flag_mismatch($sformatf("word %0d woke %b, want %b", words_checked,
                                       rsp_data.woke, want.woke));
            if (rsp_data.sleeping !== want.sleeping)
               flag_mismatch($sformatf("word %0d sleeping %b, want %b", words_checked,
                                       rsp_data.sleeping, want.sleeping));
            if (rsp_data.current_tab !== want.current_tab)
               flag_mismatch($sformatf("word %0d current_tab %0d, want %0d", words_checked,
                                       rsp_data.current_tab, want.current_tab));
            if (rsp_data.redraw !== want.redraw)
               flag_mismatch($sformatf("word %0d redraw %b, want %b", words_checked,
                                       rsp_data.redraw, want.redraw));
            case (want.press_event)
               bpsc_pkg::EV_SHORT: seen_short++;
               bpsc_pkg::EV_LONG:  seen_long++;
               bpsc_pkg::EV_SLEEP: seen_sleep++;
               default: ;
            endcase
            if (want.woke) seen_woke++;
         end
      end
   end

   // Count cycles where the block pushes back on the input channel
   always @(posedge clock) begin
      if (!reset && req_valid && !req_ready) input_stalls++;
   end

   // Run ceiling: anything still going here is hung
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("tb_button_press_sleep_controller: FAIL");
      $finish;
   end

   // ------------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------------
   function automatic bpsc_pkg::req_type tick_word(logic btn, logic wreq, logic act,
                                                   logic tv, logic [2:0] tval);
      bpsc_pkg::req_type w;
      w.button_pressed = btn;
      w.wake_request   = wreq;
      w.activity       = act;
      w.set_tab_valid  = tv;
      w.set_tab_value  = tval;
      return w;
   endfunction

   // Tick with every field random
   function automatic bpsc_pkg::req_type noise_word();
      return bpsc_pkg::req_type'(7'($urandom));
   endfunction

   // Tick with the given button level and occasional side requests
   function automatic bpsc_pkg::req_type sparse_word(logic btn);
      return tick_word(btn, $urandom_range(0, 15) == 0, $urandom_range(0, 15) == 0,
                       $urandom_range(0, 9) == 0, 3'($urandom_range(0, 7)));
   endfunction

   // Offer one tick word, wait for the handshake, then predict its status
   task automatic send_tick(input bpsc_pkg::req_type w);
      int gap;
      if (src_gaps_on && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 19);
         @(negedge clock);
         req_valid = 1'b0;
         req_data  = noise_word();
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid = 1'b1;
      req_data  = w;
      do @(posedge clock); while (!req_ready);
      status_q.push_back(next_status(w));
      words_sent++;
   endtask

   // Hold the button for the given number of ticks, then release it
   task automatic send_press(input int ticks, input logic plain);
      repeat (ticks) send_tick(plain ? tick_word(1'b1, 1'b0, 1'b0, 1'b0, 3'd0)
                                     : sparse_word(1'b1));
      send_tick(plain ? tick_word(1'b0, 1'b0, 1'b0, 1'b0, 3'd0) : sparse_word(1'b0));
   endtask

   task automatic send_idle(input int ticks);
      repeat (ticks) send_tick(tick_word(1'b0, 1'b0, 1'b0, 1'b0, 3'd0));
   endtask

   // Drop valid and wait until every predicted word has come back
   task automatic drain;
      @(negedge clock);
      req_valid = 1'b0;
      while (status_q.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   // Write all five registers while the block is idle
   task automatic apply_settings(input logic [9:0] mn, input logic [9:0] lng,
                                 input logic [15:0] slp, input logic [3:0] tabs,
                                 input logic ext);
      drain();
      @(negedge clock);
      csr_we = 1'b1; csr_index = bpsc_pkg::REG_MIN_PRESS;   csr_wdata = 16'(mn);
      @(negedge clock);
      csr_index = bpsc_pkg::REG_LONG_PRESS;  csr_wdata = 16'(lng);
      @(negedge clock);
      csr_index = bpsc_pkg::REG_SLEEP_TICKS; csr_wdata = slp;
      @(negedge clock);
      csr_index = bpsc_pkg::REG_TAB_COUNT;   csr_wdata = 16'(tabs);
      @(negedge clock);
      csr_index = bpsc_pkg::REG_BUTTON_EXT;  csr_wdata = 16'(ext);
      @(negedge clock);
      csr_we = 1'b0;
      cfg_min = mn; cfg_long = lng; cfg_sleep = slp; cfg_tabs = tabs; cfg_ext = ext;
   endtask

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------

   // Below-minimum, short and long releases while awake
   task automatic test_press_classes;
      apply_settings(10'd2, 10'd4, 16'd1000, 4'd3, 1'b0);
      send_press(1, 1'b1);
      send_press(2, 1'b1);
      send_press(4, 1'b1);
   endtask

   // Idle sleep, then every way back: wake request, activity, press
   task automatic test_sleep_and_wake;
      apply_settings(10'd2, 10'd4, 16'd1, 4'd3, 1'b0);
      send_idle(3);
      send_tick(tick_word(1'b0, 1'b1, 1'b0, 1'b0, 3'd0));
      send_idle(3);
      send_tick(tick_word(1'b0, 1'b0, 1'b1, 1'b0, 3'd0));
      send_idle(2);
      // Too short to wake, then long enough
      send_press(1, 1'b1);
      send_press(2, 1'b1);
      // Wake latched while awake fires right after the next sleep
      send_tick(tick_word(1'b0, 1'b1, 1'b0, 1'b0, 3'd0));
      send_idle(3);
   endtask

   // Tab select clamping, out-of-range tab counts, tab kept past the count
   task automatic test_tab_select;
      apply_settings(10'd0, 10'd1, 16'd65534, 4'd0, 1'b0);
      send_tick(tick_word(1'b0, 1'b0, 1'b0, 1'b1, 3'd7));
      send_press(1, 1'b1);
      apply_settings(10'd0, 10'd1023, 16'd65534, 4'd15, 1'b0);
      send_tick(tick_word(1'b0, 1'b0, 1'b0, 1'b1, 3'd7));
      apply_settings(10'd0, 10'd1023, 16'd65534, 4'd2, 1'b0);
      send_press(1, 1'b1);
   endtask

   // External button: the press is ignored and the hold count is frozen
   task automatic test_button_external;
      apply_settings(10'd1, 10'd3, 16'd1000, 4'd1, 1'b0);
      send_tick(tick_word(1'b1, 1'b0, 1'b0, 1'b0, 3'd0));
      send_tick(tick_word(1'b1, 1'b0, 1'b0, 1'b0, 3'd0));
      apply_settings(10'd1, 10'd3, 16'd1000, 4'd1, 1'b1);
      send_press(3, 1'b1);
      apply_settings(10'd1, 10'd3, 16'd1000, 4'd1, 1'b0);
      send_tick(tick_word(1'b0, 1'b0, 1'b0, 1'b0, 3'd0));
   endtask

   // Long press with the sleep limit at its top, where idle can never pass it
   task automatic test_top_settings;
      apply_settings(10'd40, 10'd60, 16'hFFFF, 4'd8, 1'b0);
      send_press(70, 1'b1);
   endtask

   // Receiver holds off while the sender keeps offering words
   task automatic test_backpressure;
      apply_settings(10'd1, 10'd3, 16'd20, 4'd4, 1'b0);
      src_gaps_on = 1'b0;
      @(posedge clock);
      hold_off_left = 60;
      repeat (20) send_tick(sparse_word(1'($urandom_range(0, 1))));
      src_gaps_on = 1'b1;
   endtask

   // Randomized press sequences, idle runs and noise under one setting
   task automatic run_random_phase(input int budget);
      int stop_at;
      int len;
      stop_at = words_sent + budget;
      while (words_sent < stop_at) begin
         case ($urandom_range(0, 7))
            0, 1, 2, 3: begin
               // Press lengths cluster at the class boundaries
               case ($urandom_range(0, 4))
                  0: len = int'(cfg_min);
                  1: len = int'(cfg_min) - 1;
                  2: len = int'(cfg_long);
                  3: len = int'(cfg_long) - 1;
                  default: len = $urandom_range(1, int'(cfg_long) + 3);
               endcase
               if (len < 1) len = 1;
               send_press(len, 1'b0);
            end
            4, 5: begin
               len = $urandom_range(1, int'(cfg_sleep) + 5);
               if (len > 50) len = 50;
               repeat (len) send_tick(sparse_word(1'b0));
            end
            default: begin
               repeat ($urandom_range(1, 6)) send_tick(noise_word());
            end
         endcase
      end
   endtask

   task automatic test_random;
      int phase;
      for (phase = 0; phase < 8; phase++) begin
         apply_settings(10'($urandom_range(0, 12)), 10'($urandom_range(1, 20)),
                        16'($urandom_range(1, 40)), 4'($urandom_range(0, 15)),
                        $urandom_range(0, 5) == 0);
         // Last phase runs flat out on both sides
         if (phase == 7) begin
            src_gaps_on  = 1'b0;
            sink_gaps_on = 1'b0;
         end
         run_random_phase(80);
      end
   endtask

   // ------------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------------
   initial begin
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      csr_we    = 1'b0;
      csr_index = bpsc_pkg::REG_MIN_PRESS;
      csr_wdata = '0;
      cfg_min   = bpsc_pkg::MIN_PRESS_RESET;
      cfg_long  = bpsc_pkg::LONG_PRESS_RESET;
      cfg_sleep = bpsc_pkg::SLEEP_TICKS_RESET;
      cfg_tabs  = bpsc_pkg::TAB_COUNT_RESET;
      cfg_ext   = 1'b0;
      st_asleep = 1'b0;
      st_wake   = 1'b0;
      st_held   = 1'b0;
      st_hold   = '0;
      st_idle   = '0;
      st_tab    = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // A brief press under the reset settings first
      send_press(2, 1'b1);
      test_press_classes();
      test_sleep_and_wake();
      test_tab_select();
      test_button_external();
      test_top_settings();
      test_backpressure();
      test_random();

      drain();
      repeat (4) @(posedge clock);
      $display("Checked %0d status words from %0d ticks; %0d input stall cycles.",
               words_checked, words_sent, input_stalls);
      $display("Events seen: %0d short, %0d long, %0d sleep, %0d wake.",
               seen_short, seen_long, seen_sleep, seen_woke);
      if (mismatch_count == 0 && status_q.size() == 0) begin
         $display("tb_button_press_sleep_controller: PASS");
      end else begin
         $display("tb_button_press_sleep_controller: FAIL");
      end
      $finish;
   end

endmodule
